### src/fpsc_pkg.sv
// Package of types and constants for the flow PID speed controller.
`default_nettype none

package fpsc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgGainP      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainI      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainD      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIntegMax   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIntegMin   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgFlowCorr   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSingleBelow = 3'd6;

  localparam logic signed [15:0] IntegMaxRst    = 16'sd100;
  localparam logic signed [15:0] IntegMinRst    = -16'sd100;
  localparam logic [9:0]         SingleBelowRst = 10'd400;

  typedef struct packed {
    logic [11:0] sensor_a_rate;
    logic [11:0] sensor_b_rate;
    logic [9:0]  target_speed;
    logic        at_max_limit;
    logic        at_min_limit;
  } fpsc_in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic [15:0]        measured_speed;
    logic               single_pump;
  } fpsc_out_t;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic signed [15:0] integrator_max;
    logic signed [15:0] integrator_min;
    logic [15:0]        flow_correction;
    logic [9:0]         single_pump_below;
  } fpsc_cfg_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [9:0]  target;
    logic        single;
    logic        lim_max;
    logic        lim_min;
  } fpsc_s1_t;

  typedef struct packed {
    logic signed [16:0] err;
    logic signed [15:0] integ;
    logic signed [16:0] dspeed;
    logic [15:0]        speed;
    logic               single;
    logic               lim_max;
    logic               lim_min;
  } fpsc_s2_t;

  typedef struct packed {
    logic signed [32:0] p_term;
    logic signed [31:0] i_term;
    logic signed [32:0] d_term;
    logic [15:0]        speed;
    logic               single;
    logic               lim_max;
    logic               lim_min;
  } fpsc_s3_t;

endpackage

`default_nettype wire

### src/fpsc_speed.sv
// First stage: sensor rate combination, flow correction and speed saturation.
`default_nettype none

module fpsc_speed (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fpsc_pkg::fpsc_cfg_t cfg_i,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire fpsc_pkg::fpsc_in_t data_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output fpsc_pkg::fpsc_s1_t      data_o
);
  import fpsc_pkg::*;

  logic        valid_q, valid_d;
  fpsc_s1_t    data_q, data_d;
  logic        single;
  logic [12:0] rate;
  logic [28:0] prod;
  logic [27:0] half;
  logic        load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    single = data_i.target_speed < cfg_i.single_pump_below;
    if (single) begin
      if (data_i.sensor_a_rate >= data_i.sensor_b_rate) begin
        rate = {1'b0, data_i.sensor_a_rate - data_i.sensor_b_rate};
      end else begin
        rate = {1'b0, data_i.sensor_b_rate - data_i.sensor_a_rate};
      end
    end else begin
      rate = {1'b0, data_i.sensor_a_rate} + {1'b0, data_i.sensor_b_rate};
    end
    prod = 29'(rate) * 29'(cfg_i.flow_correction);
    half = prod[28:1];
    data_d.speed   = (|half[27:16]) ? 16'hFFFF : half[15:0];
    data_d.target  = data_i.target_speed;
    data_d.single  = single;
    data_d.lim_max = data_i.at_max_limit;
    data_d.lim_min = data_i.at_min_limit;
  end

  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/fpsc_integ.sv
// Second stage: error, clamped integrator and speed difference state.
`default_nettype none

module fpsc_integ (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fpsc_pkg::fpsc_cfg_t cfg_i,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire fpsc_pkg::fpsc_s1_t  data_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output fpsc_pkg::fpsc_s2_t       data_o
);
  import fpsc_pkg::*;

  logic               valid_q, valid_d;
  fpsc_s2_t           data_q, data_d;
  logic signed [15:0] integ_q, integ_d;
  logic [15:0]        prev_q;
  logic signed [16:0] err;
  logic signed [17:0] acc;
  logic signed [17:0] max_ext, min_ext;
  logic               load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    err     = $signed({7'b0, data_i.target}) - $signed({1'b0, data_i.speed});
    acc     = 18'(integ_q) + 18'(err);
    max_ext = 18'(cfg_i.integrator_max);
    min_ext = 18'(cfg_i.integrator_min);
    if (acc > max_ext) begin
      integ_d = cfg_i.integrator_max;
    end else if (acc < min_ext) begin
      integ_d = cfg_i.integrator_min;
    end else begin
      integ_d = acc[15:0];
    end
    data_d.err     = err;
    data_d.integ   = integ_d;
    data_d.dspeed  = $signed({1'b0, data_i.speed}) - $signed({1'b0, prev_q});
    data_d.speed   = data_i.speed;
    data_d.single  = data_i.single;
    data_d.lim_max = data_i.lim_max;
    data_d.lim_min = data_i.lim_min;
  end

  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (load) begin
        integ_q <= integ_d;
        prev_q  <= data_i.speed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/fpsc_mult.sv
// Third stage: the three gain products.
`default_nettype none

module fpsc_mult (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fpsc_pkg::fpsc_cfg_t cfg_i,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire fpsc_pkg::fpsc_s2_t  data_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output fpsc_pkg::fpsc_s3_t       data_o
);
  import fpsc_pkg::*;

  logic     valid_q, valid_d;
  fpsc_s3_t data_q, data_d;
  logic     load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    data_d.p_term  = 33'(cfg_i.gain_p) * 33'(data_i.err);
    data_d.i_term  = 32'(cfg_i.gain_i) * 32'(data_i.integ);
    data_d.d_term  = 33'(cfg_i.gain_d) * 33'(data_i.dspeed);
    data_d.speed   = data_i.speed;
    data_d.single  = data_i.single;
    data_d.lim_max = data_i.lim_max;
    data_d.lim_min = data_i.lim_min;
  end

  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/fpsc_drive.sv
// Fourth stage: PID sum, 32-bit saturation, limit-switch gating and result register.
`default_nettype none

module fpsc_drive (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire fpsc_pkg::fpsc_s3_t data_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output fpsc_pkg::fpsc_out_t     data_o
);
  import fpsc_pkg::*;

  logic               valid_q, valid_d;
  fpsc_out_t          data_q, data_d;
  logic signed [34:0] sum;
  logic signed [31:0] sat;
  logic               load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    sum = 35'(data_i.p_term) + 35'(data_i.i_term) - 35'(data_i.d_term);
    if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
      sat = sum[31:0];
    end else if (sum[34]) begin
      sat = {1'b1, 31'b0};
    end else begin
      sat = {1'b0, {31{1'b1}}};
    end
    data_d.drive = sat;
    if (!sat[31] && (sat != '0) && data_i.lim_max) begin
      data_d.drive = '0;
    end
    if (sat[31] && data_i.lim_min) begin
      data_d.drive = '0;
    end
    data_d.measured_speed = data_i.speed;
    data_d.single_pump    = data_i.single;
  end

  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/flow_pid_speed_controller_core.sv
// Top level of the flow PID speed controller: configuration registers and the four-stage pipeline.

// The controller accepts one control tick per clock cycle unless back-pressure stalls it, and
// returns its result through the registered stages of speed measurement, integrator update,
// gain products and saturated sum with limit gating. The integrator and the previous speed
// are updated in the second stage, so consecutive ticks follow without gaps. Each stage
// holds its transaction while the stage after it is full, so back-pressure on the result
// channel fills the pipeline before the input channel stalls. Configuration writes are
// always accepted and should only be made while no tick is in flight.
`default_nettype none

module flow_pid_speed_controller_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire fpsc_pkg::fpsc_in_t                  in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output fpsc_pkg::fpsc_out_t                      out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [fpsc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [fpsc_pkg::CfgDataW-1:0]       cfg_data_i
);
  import fpsc_pkg::*;

  fpsc_cfg_t cfg_q, cfg_d;
  logic      s1_valid, s1_ready;
  logic      s2_valid, s2_ready;
  logic      s3_valid, s3_ready;
  fpsc_s1_t  s1_data;
  fpsc_s2_t  s2_data;
  fpsc_s3_t  s3_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGainP:       cfg_d.gain_p            = cfg_data_i;
        CfgGainI:       cfg_d.gain_i            = cfg_data_i;
        CfgGainD:       cfg_d.gain_d            = cfg_data_i;
        CfgIntegMax:    cfg_d.integrator_max    = cfg_data_i;
        CfgIntegMin:    cfg_d.integrator_min    = cfg_data_i;
        CfgFlowCorr:    cfg_d.flow_correction   = cfg_data_i;
        CfgSingleBelow: cfg_d.single_pump_below = cfg_data_i[9:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p            <= '0;
      cfg_q.gain_i            <= '0;
      cfg_q.gain_d            <= '0;
      cfg_q.integrator_max    <= IntegMaxRst;
      cfg_q.integrator_min    <= IntegMinRst;
      cfg_q.flow_correction   <= '0;
      cfg_q.single_pump_below <= SingleBelowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fpsc_speed u_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  fpsc_integ u_integ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  fpsc_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  fpsc_drive u_drive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .data_i  (s3_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // An accepted tick always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid)
    else $error("accepted tick did not reach the first stage");

  // A full pipeline with a stalled result must stall the input.
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s2_valid && s3_valid && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline full and stalled");

  // With no flow correction the measured speed is always zero.
  a_zero_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cfg_q.flow_correction == '0) |-> (out_data_o.measured_speed == '0))
    else $error("non-zero speed with zero flow correction");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the flow PID speed controller core.
`default_nettype none

module tb_top;
  import fpsc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
  localparam int DrainCycles = 8;
  localparam int IdleLimit = 2000;
  localparam int RandomPhases = 10;
  localparam int TicksPerPhase = 175;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  fpsc_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  fpsc_out_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  flow_pid_speed_controller_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the controller registers and state.
  logic signed [15:0] kp_model;
  logic signed [15:0] ki_model;
  logic signed [15:0] kd_model;
  logic signed [15:0] integ_max_model;
  logic signed [15:0] integ_min_model;
  logic [15:0]        flow_corr_model;
  logic [9:0]         single_below_model;
  logic signed [15:0] integ_model;
  logic [15:0]        prev_speed_model;

  fpsc_out_t   pending_cmds[$];
  int          fails;
  int          burst_left;
  int unsigned ready_mode;
  int unsigned ready_left;
  int          idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic fpsc_out_t compute_drive(input fpsc_in_t t);
    fpsc_out_t r;
    logic      single;
    longint    rate;
    longint    scaled;
    longint    speed;
    longint    err;
    longint    acc;
    longint    dspeed;
    longint    d;
    single = (t.target_speed < single_below_model);
    if (single) begin
      rate = (t.sensor_a_rate >= t.sensor_b_rate) ?
             longint'(t.sensor_a_rate) - longint'(t.sensor_b_rate) :
             longint'(t.sensor_b_rate) - longint'(t.sensor_a_rate);
    end else begin
      rate = longint'(t.sensor_a_rate) + longint'(t.sensor_b_rate);
    end
    scaled = (rate * longint'(flow_corr_model)) / 2;
    speed = (scaled > 65535) ? 65535 : scaled;
    err = longint'(t.target_speed) - speed;
    acc = longint'(integ_model) + err;
    if (acc > longint'(integ_max_model)) begin
      acc = longint'(integ_max_model);
    end else if (acc < longint'(integ_min_model)) begin
      acc = longint'(integ_min_model);
    end
    integ_model = acc[15:0];
    dspeed = speed - longint'(prev_speed_model);
    prev_speed_model = speed[15:0];
    d = longint'(kp_model) * err + longint'(ki_model) * longint'(integ_model)
        - longint'(kd_model) * dspeed;
    if (d > 64'sd2147483647) begin
      d = 64'sd2147483647;
    end else if (d < -64'sd2147483648) begin
      d = -64'sd2147483648;
    end
    if (d > 0 && t.at_max_limit) begin
      d = 0;
    end
    if (d < 0 && t.at_min_limit) begin
      d = 0;
    end
    r.drive = d[31:0];
    r.measured_speed = speed[15:0];
    r.single_pump = single;
    return r;
  endfunction

  function automatic fpsc_in_t mk_tick(input logic [11:0] a, input logic [11:0] b,
                                       input logic [9:0] target, input logic lim_max,
                                       input logic lim_min);
    fpsc_in_t t;
    t.sensor_a_rate = a;
    t.sensor_b_rate = b;
    t.target_speed = target;
    t.at_max_limit = lim_max;
    t.at_min_limit = lim_min;
    return t;
  endfunction

  function automatic fpsc_cfg_t base_cfg();
    fpsc_cfg_t c;
    c.gain_p = '0;
    c.gain_i = '0;
    c.gain_d = '0;
    c.integrator_max = IntegMaxRst;
    c.integrator_min = IntegMinRst;
    c.flow_correction = '0;
    c.single_pump_below = SingleBelowRst;
    return c;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 6))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_tick(input fpsc_in_t t);
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    pending_cmds.push_back(compute_drive(t));
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) :
                   $urandom_range(1, 24);
    end
  endtask

  // Waits until every tick has returned, then lets the pipeline settle.
  task automatic drain_ticks();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgGainP:       kp_model = val;
      CfgGainI:       ki_model = val;
      CfgGainD:       kd_model = val;
      CfgIntegMax:    integ_max_model = val;
      CfgIntegMin:    integ_min_model = val;
      CfgFlowCorr:    flow_corr_model = val;
      CfgSingleBelow: single_below_model = val[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input fpsc_cfg_t c, input bit poke_unused);
    drain_ticks();
    write_reg(CfgGainP, c.gain_p);
    write_reg(CfgGainI, c.gain_i);
    write_reg(CfgGainD, c.gain_d);
    if (poke_unused) begin
      write_reg(CfgUnused, 16'($urandom));
    end
    write_reg(CfgIntegMax, c.integrator_max);
    write_reg(CfgIntegMin, c.integrator_min);
    write_reg(CfgFlowCorr, c.flow_correction);
    write_reg(CfgSingleBelow, {6'($urandom), c.single_pump_below});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_tick(mk_tick(12'd4095, 12'd0, 10'd1023, 1'b0, 1'b0));
    send_tick(mk_tick(12'd0, 12'd4095, 10'd0, 1'b1, 1'b1));
  endtask

  task automatic test_measurement();
    fpsc_cfg_t c;
    c = base_cfg();
    c.flow_correction = 16'd1;
    c.gain_p = 16'sd1;
    c.gain_d = 16'sd1;
    apply_cfg(c, 1'b1);
    send_tick(mk_tick(12'd100, 12'd30, 10'd10, 1'b0, 1'b0));
    send_tick(mk_tick(12'd30, 12'd100, 10'd10, 1'b0, 1'b0));
    send_tick(mk_tick(12'd2000, 12'd2000, 10'd10, 1'b0, 1'b0));
    send_tick(mk_tick(12'd100, 12'd30, 10'd400, 1'b0, 1'b0));
    send_tick(mk_tick(12'd4095, 12'd4095, 10'd1023, 1'b0, 1'b0));
    send_tick(mk_tick(12'd7, 12'd0, 10'd399, 1'b0, 1'b0));
    c.single_pump_below = 10'd0;
    apply_cfg(c, 1'b0);
    send_tick(mk_tick(12'd100, 12'd30, 10'd0, 1'b0, 1'b0));
    c.single_pump_below = 10'd1023;
    apply_cfg(c, 1'b0);
    send_tick(mk_tick(12'd100, 12'd30, 10'd1022, 1'b0, 1'b0));
  endtask

  task automatic test_speed_saturation();
    fpsc_cfg_t c;
    c = base_cfg();
    c.flow_correction = 16'hffff;
    c.gain_p = 16'sd1;
    apply_cfg(c, 1'b0);
    send_tick(mk_tick(12'd4095, 12'd4095, 10'd500, 1'b0, 1'b0));
    send_tick(mk_tick(12'd1, 12'd0, 10'd0, 1'b0, 1'b0));
  endtask

  task automatic test_integrator_clamp();
    fpsc_cfg_t c;
    c = base_cfg();
    c.gain_i = 16'sd1;
    c.integrator_max = -16'sd5;
    c.integrator_min = 16'sd5;
    apply_cfg(c, 1'b0);
    send_tick(mk_tick(12'd0, 12'd0, 10'd0, 1'b0, 1'b0));
    send_tick(mk_tick(12'd0, 12'd0, 10'd1023, 1'b0, 1'b0));
    send_tick(mk_tick(12'd0, 12'd0, 10'd0, 1'b0, 1'b0));
    c.integrator_max = 16'sh7fff;
    c.integrator_min = 16'sh8000;
    c.flow_correction = 16'hffff;
    apply_cfg(c, 1'b0);
    send_tick(mk_tick(12'd4095, 12'd4095, 10'd0, 1'b0, 1'b0));
    send_tick(mk_tick(12'd4095, 12'd4095, 10'd0, 1'b0, 1'b0));
  endtask

  task automatic test_drive_saturation();
    fpsc_cfg_t c;
    c = base_cfg();
    c.integrator_max = 16'sh7fff;
    c.integrator_min = 16'sh8000;
    c.flow_correction = 16'hffff;
    c.gain_p = 16'sh8000;
    c.gain_i = 16'sh8000;
    apply_cfg(c, 1'b0);
    send_tick(mk_tick(12'd4095, 12'd4095, 10'd0, 1'b0, 1'b0));
    c.gain_p = 16'sh7fff;
    c.gain_i = 16'sh7fff;
    c.gain_d = 16'sh7fff;
    apply_cfg(c, 1'b0);
    send_tick(mk_tick(12'd4095, 12'd4095, 10'd0, 1'b0, 1'b0));
  endtask

  task automatic test_limit_gating();
    fpsc_cfg_t c;
    c = base_cfg();
    c.gain_p = 16'sd1;
    apply_cfg(c, 1'b0);
    send_tick(mk_tick(12'd0, 12'd0, 10'd5, 1'b1, 1'b0));
    send_tick(mk_tick(12'd0, 12'd0, 10'd5, 1'b0, 1'b1));
    send_tick(mk_tick(12'd0, 12'd0, 10'd5, 1'b1, 1'b1));
    c.gain_p = -16'sd1;
    apply_cfg(c, 1'b0);
    send_tick(mk_tick(12'd0, 12'd0, 10'd5, 1'b0, 1'b1));
    send_tick(mk_tick(12'd0, 12'd0, 10'd5, 1'b1, 1'b0));
    send_tick(mk_tick(12'd0, 12'd0, 10'd0, 1'b1, 1'b1));
  endtask

  task automatic test_random_ticks();
    fpsc_cfg_t c;
    fpsc_in_t  t;
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) begin
        c.gain_p = 16'sh7fff;
        c.gain_i = 16'sh7fff;
        c.gain_d = 16'sh7fff;
        c.integrator_max = 16'sh7fff;
        c.integrator_min = 16'sh8000;
        c.flow_correction = 16'hffff;
        c.single_pump_below = 10'd1023;
      end else if (p == 1) begin
        c.gain_p = 16'sh8000;
        c.gain_i = 16'sh8000;
        c.gain_d = 16'sh8000;
        c.integrator_max = 16'sh8000;
        c.integrator_min = 16'sh7fff;
        c.flow_correction = 16'h0000;
        c.single_pump_below = 10'd0;
      end else begin
        c.gain_p = pick_word();
        c.gain_i = pick_word();
        c.gain_d = pick_word();
        c.integrator_max = pick_word();
        c.integrator_min = pick_word();
        c.flow_correction = ($urandom_range(0, 3) == 0) ? pick_word() :
                            16'($urandom_range(0, 16));
        c.single_pump_below = 10'($urandom);
      end
      apply_cfg(c, 1'($urandom_range(0, 1)));
      for (int n = 0; n < TicksPerPhase; n++) begin
        t.sensor_a_rate = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 15)) :
                          12'($urandom);
        case ($urandom_range(0, 5))
          0: t.sensor_b_rate = t.sensor_a_rate;
          1: t.sensor_b_rate = 12'($urandom_range(0, 15));
          default: t.sensor_b_rate = 12'($urandom);
        endcase
        t.target_speed = ($urandom_range(0, 3) == 0) ?
                         single_below_model + 10'($urandom_range(0, 2)) - 10'd1 :
                         10'($urandom);
        t.at_max_limit = 1'($urandom_range(0, 1));
        t.at_min_limit = 1'($urandom_range(0, 1));
        send_tick(t);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    fails       = 0;
    burst_left  = 1;
    ready_mode  = 0;
    ready_left  = 0;
    idle_cycles = 0;
    kp_model           = '0;
    ki_model           = '0;
    kd_model           = '0;
    integ_max_model    = IntegMaxRst;
    integ_min_model    = IntegMinRst;
    flow_corr_model    = '0;
    single_below_model = SingleBelowRst;
    integ_model        = '0;
    prev_speed_model   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_measurement();
    test_speed_saturation();
    test_integrator_clamp();
    test_drive_saturation();
    test_limit_gating();
    test_random_ticks();
    drain_ticks();
    if (fails == 0) begin
      $display("** flow_pid_speed_controller_core: PASSED **");
    end else begin
      $display("** flow_pid_speed_controller_core: FAILED **");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(5, 120);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= (ready_left % 4 != 0);
    endcase
  end

  // Each result transaction is checked against the oldest pending tick.
  always @(posedge clk_i) begin
    fpsc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected result: drive %0d, measured_speed %0d, single_pump %0d",
               $signed(out_data_o.drive), out_data_o.measured_speed,
               out_data_o.single_pump);
        fails++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_data_o.drive !== want.drive) begin
          $error("drive: expected %0d, actual %0d", $signed(want.drive),
                 $signed(out_data_o.drive));
          fails++;
        end
        if (out_data_o.measured_speed !== want.measured_speed) begin
          $error("measured_speed: expected %0d, actual %0d", want.measured_speed,
                 out_data_o.measured_speed);
          fails++;
        end
        if (out_data_o.single_pump !== want.single_pump) begin
          $error("single_pump: expected %0d, actual %0d", want.single_pump,
                 out_data_o.single_pump);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("** flow_pid_speed_controller_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

### files.f
src/fpsc_pkg.sv
src/fpsc_speed.sv
src/fpsc_integ.sv
src/fpsc_mult.sv
src/fpsc_drive.sv
src/flow_pid_speed_controller_core.sv
tb/tb_top.sv
